// ----- rtl/srgbl_pkg.sv -----
// srgbl_pkg: shared widths, payload structs, register codes and constant tables
// for the sRGB to CIELAB converter. No dependencies.
package srgbl_pkg;

    localparam int LIN_W     = 25;
    localparam int S_W       = 38;
    localparam int N_W       = 48;
    localparam int D_W       = 24;
    localparam int Q_W       = 42;
    localparam int T20_W     = 38;
    localparam int CB_BITS   = 26;
    localparam int F_W       = 26;
    localparam int SQ_W      = 52;
    localparam int PROD_W    = 58;
    localparam int WHITE_W   = 17;
    localparam int THR_W     = 24;
    localparam int SLOPE_W   = 18;
    localparam int CFG_W     = 24;
    localparam int IDX_W     = 3;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [WHITE_W-1:0] WHITE_X_RST = 17'd97328;
    localparam logic [WHITE_W-1:0] WHITE_Y_RST = 17'd102400;
    localparam logic [WHITE_W-1:0] WHITE_Z_RST = 17'd111496;
    localparam logic [THR_W-1:0]   THR_RST     = 24'd148577;
    localparam logic [SLOPE_W-1:0] SLOPE_RST   = 18'd231245;

    // reciprocal of 116 in Q38
    localparam int RECIP_SH = 38;
    localparam longint unsigned RECIP_116_L = (64'd1 << RECIP_SH) / 116;
    localparam logic [31:0] RECIP_116 = RECIP_116_L[31:0];

    typedef enum logic [IDX_W-1:0] {
        REG_WHITE_X      = 3'd0,
        REG_WHITE_Y      = 3'd1,
        REG_WHITE_Z      = 3'd2,
        REG_CUBE_THR     = 3'd3,
        REG_LINEAR_SLOPE = 3'd4
    } srgbl_reg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } srgbl_pixel_t;

    typedef struct packed {
        logic [14:0]        lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
    } srgbl_lab_t;

    typedef struct packed {
        logic [S_W-1:0] sx;
        logic [S_W-1:0] sy;
        logic [S_W-1:0] sz;
    } srgbl_xyz_t;

    typedef logic [LIN_W-1:0] lin_table_t [256];

    // rows X, Y, Z times 10000
    localparam logic [13:0] MATRIX [3][3] = '{
        '{14'd4124, 14'd3576, 14'd1805},
        '{14'd2126, 14'd7152, 14'd722},
        '{14'd193,  14'd1192, 14'd9505}
    };

    // sRGB decode curve, Q1.24, built at elaboration
    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        longint unsigned u;
        longint unsigned r;
        longint unsigned cand;
        longint unsigned p;
        longint unsigned c;
        int ci;
        int bi;
        int ki;
        for (ci = 0; ci < 256; ci++)
        begin
            c = longint'(ci);
            if (ci <= 10)
            begin
                tbl[ci] = LIN_W'((c * 100 * (64'd1 << 24) + 164730) / 329460);
            end
            else
            begin
                u = (((1000 * c + 14025) << 24) + 134512) / 269025;
                r = 0;
                for (bi = 24; bi >= 0; bi--)
                begin
                    cand = r | (64'd1 << bi);
                    p = cand;
                    for (ki = 0; ki < 4; ki++)
                    begin
                        p = (p * cand) >> 24;
                    end
                    if (p <= u)
                    begin
                        r = cand;
                    end
                end
                tbl[ci] = LIN_W'((((u * u) >> 24) * ((r * r) >> 24)) >> 24);
            end
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

// ----- rtl/srgbl_front.sv -----
// srgbl_front: accepts pixels, linearizes each channel by table and forms XYZ sums.
// Depends on srgbl_pkg.
module srgbl_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  srgbl_pkg::srgbl_pixel_t  pixel,
    output logic                     out_valid,
    output srgbl_pkg::srgbl_xyz_t    xyz,
    output logic [1:0]               inflight
);
    import srgbl_pkg::*;

    logic             v1_reg, v2_reg, v3_reg;
    logic [LIN_W-1:0] lin_reg [3];
    logic [S_W-1:0]   prod_reg [3][3];
    logic [S_W-1:0]   sum_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg[0] <= LIN_TABLE[pixel.red];
        lin_reg[1] <= LIN_TABLE[pixel.green];
        lin_reg[2] <= LIN_TABLE[pixel.blue];
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                prod_reg[i][j] <= S_W'(MATRIX[i][j]) * S_W'(lin_reg[j]);
            end
        end
        always_ff @(posedge clk)
        begin
            sum_reg[i] <= prod_reg[i][0] + prod_reg[i][1] + prod_reg[i][2];
        end
    end

    assign out_valid = v3_reg;
    assign xyz       = '{sx: sum_reg[0], sy: sum_reg[1], sz: sum_reg[2]};
    assign inflight  = 2'(v1_reg) + 2'(v2_reg) + 2'(v3_reg);

endmodule

// ----- rtl/srgbl_fifo.sv -----
// srgbl_fifo: short register queue between front and back parts.
// Depends on srgbl_pkg.
module srgbl_fifo #(
    parameter int DEPTH = srgbl_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  srgbl_pkg::srgbl_xyz_t         wdata,
    input  logic                          pop,
    output srgbl_pkg::srgbl_xyz_t         rdata,
    output logic                          empty,
    output logic                          full,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import srgbl_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    srgbl_xyz_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign count   = cnt_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/srgbl_div.sv -----
// srgbl_div: pipelined restoring divider, one quotient bit per stage.
// Depends on srgbl_pkg.
module srgbl_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  logic [srgbl_pkg::N_W-1:0] num,
    input  logic [srgbl_pkg::D_W-1:0] den,
    output logic                      valid_out,
    output logic [srgbl_pkg::Q_W-1:0] quot
);
    import srgbl_pkg::*;

    logic             valid_reg [Q_W];
    logic [D_W-1:0]   rem_reg [Q_W];
    logic [Q_W-1:0]   nq_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic           vin;
        logic [D_W-1:0] rem_in;
        logic [Q_W-1:0] nq_in;
        logic [D_W:0]   shifted;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign vin    = valid_in;
            assign rem_in = D_W'(num[N_W-1:Q_W]);
            assign nq_in  = num[Q_W-1:0];
        end
        else
        begin : g_next
            assign vin    = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
        end

        assign shifted = {rem_in, nq_in[Q_W-1]};
        assign ge      = (shifted >= {1'b0, den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? D_W'(shifted - {1'b0, den}) : D_W'(shifted);
            nq_reg[k]  <= {nq_in[Q_W-2:0], ge};
        end
    end

    assign valid_out = valid_reg[Q_W-1];
    assign quot      = nq_reg[Q_W-1];

endmodule

// ----- rtl/srgbl_pivot.sv -----
// srgbl_pivot: CIELAB pivot f(t): pipelined cube root or kappa linear segment.
// Depends on srgbl_pkg.
module srgbl_pivot (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic [srgbl_pkg::Q_W-1:0]     t,
    input  logic [srgbl_pkg::THR_W-1:0]   thr,
    input  logic [srgbl_pkg::SLOPE_W-1:0] slope,
    output logic                          valid_out,
    output logic [srgbl_pkg::F_W-1:0]     f_out
);
    import srgbl_pkg::*;

    localparam int LIN_DLY = 2 * CB_BITS - 3;

    // cube root search, two stages per result bit
    logic              a_valid [CB_BITS];
    logic [F_W-1:0]    a_f     [CB_BITS];
    logic [SQ_W-1:0]   a_sq    [CB_BITS];
    logic [SQ_W-1:0]   a_csq   [CB_BITS];
    logic [PROD_W-1:0] a_prod  [CB_BITS];
    logic [T20_W-1:0]  a_t20   [CB_BITS];
    logic              b_valid [CB_BITS];
    logic [F_W-1:0]    b_f     [CB_BITS];
    logic [SQ_W-1:0]   b_sq    [CB_BITS];
    logic [T20_W-1:0]  b_t20   [CB_BITS];

    for (genvar k = 0; k < CB_BITS; k++)
    begin : g_bit
        localparam int B = CB_BITS - 1 - k;
        logic             vin;
        logic [F_W-1:0]   f_in;
        logic [SQ_W-1:0]  sq_in;
        logic [T20_W-1:0] t20_in;
        logic [F_W-1:0]   cand;
        logic [SQ_W-1:0]  csq;
        logic [F_W-1:0]   a_cand;
        logic             ok;

        if (k == 0)
        begin : g_first
            assign vin    = valid_in;
            assign f_in   = '0;
            assign sq_in  = '0;
            assign t20_in = t[Q_W-1:4];
        end
        else
        begin : g_next
            assign vin    = b_valid[k-1];
            assign f_in   = b_f[k-1];
            assign sq_in  = b_sq[k-1];
            assign t20_in = b_t20[k-1];
        end

        // (f + 2^B)^2 = f^2 + f*2^(B+1) + 2^(2B)
        assign cand   = f_in | (F_W'(1) << B);
        assign csq    = sq_in + (SQ_W'(f_in) << (B + 1)) + (SQ_W'(1) << (2 * B));
        assign a_cand = a_f[k] | (F_W'(1) << B);
        assign ok     = (a_prod[k][PROD_W-1:20] <= a_t20[k]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_valid[k] <= 1'b0;
                b_valid[k] <= 1'b0;
            end
            else
            begin
                a_valid[k] <= vin;
                b_valid[k] <= a_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            a_f[k]    <= f_in;
            a_sq[k]   <= sq_in;
            a_csq[k]  <= csq;
            a_prod[k] <= PROD_W'(csq[SQ_W-1:20]) * PROD_W'(cand);
            a_t20[k]  <= t20_in;
            b_f[k]    <= ok ? a_cand : a_f[k];
            b_sq[k]   <= ok ? a_csq[k] : a_sq[k];
            b_t20[k]  <= a_t20[k];
        end
    end

    // linear segment: (kappa*t + 16*2^32 + 58*2^12) / (116*2^12)
    logic             l1_sel_reg;
    logic [41:0]      l1_m_reg;
    logic             l2_sel_reg;
    logic [30:0]      l2_x_reg;
    logic [62:0]      l2_q_reg;
    logic             l3_sel_reg;
    logic [F_W-1:0]   l3_f_reg;
    logic [42:0]      l1_num;
    logic [24:0]      q0;
    logic [31:0]      rem;
    logic             dl_sel [LIN_DLY];
    logic [F_W-1:0]   dl_f   [LIN_DLY];
    logic             out_valid_reg;
    logic [F_W-1:0]   f_reg;

    assign l1_num = {1'b0, l1_m_reg} + (43'd1 << 36) + 43'd237568;
    assign q0     = l2_q_reg[62:RECIP_SH];
    assign rem    = 32'(l2_x_reg) - 32'(q0) * 32'd116;

    always_ff @(posedge clk)
    begin
        l1_sel_reg <= (t > Q_W'(thr));
        l1_m_reg   <= 42'(slope) * 42'(t[THR_W-1:0]);
        l2_sel_reg <= l1_sel_reg;
        l2_x_reg   <= l1_num[42:12];
        l2_q_reg   <= 63'(l1_num[42:12]) * 63'(RECIP_116);
        l3_sel_reg <= l2_sel_reg;
        l3_f_reg   <= (rem >= 32'd116) ? F_W'(q0 + 25'd1) : F_W'(q0);
    end

    for (genvar d = 0; d < LIN_DLY; d++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            dl_sel[d] <= (d == 0) ? l3_sel_reg : dl_sel[(d == 0) ? 0 : d - 1];
            dl_f[d]   <= (d == 0) ? l3_f_reg   : dl_f[(d == 0) ? 0 : d - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= b_valid[CB_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg <= dl_sel[LIN_DLY-1] ? b_f[CB_BITS-1] : dl_f[LIN_DLY-1];
    end

    assign valid_out = out_valid_reg;
    assign f_out     = f_reg;

endmodule

// ----- rtl/srgb_to_cielab.sv -----
// srgb_to_cielab: top level, 8-bit sRGB pixel in, CIELAB (Q8) out.
// Depends on srgbl_pkg, srgbl_front, srgbl_fifo, srgbl_div, srgbl_pivot.
//
//  channel   signals                            transfer at clock edge
//  input     start, busy, pixel                 start && !busy
//  result    done, lab                          done (one cycle, no stall)
//  config    cfg_write, cfg_index, cfg_data     cfg_write
//
// One pixel per cycle sustained while busy is low; the deepest parts are the
// 42-stage XYZ/white divider and the 52-stage cube root search.
// Reset loads the D65 white and default epsilon and kappa; no clearing pass.
// busy rises only when the queue between front and back could overflow.
module srgb_to_cielab #(
    parameter int FIFO_DEPTH = srgbl_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  srgbl_pkg::srgbl_pixel_t       pixel,
    output logic                          done,
    output srgbl_pkg::srgbl_lab_t         lab,
    input  logic                          cfg_write,
    input  logic [srgbl_pkg::IDX_W-1:0]   cfg_index,
    input  logic [srgbl_pkg::CFG_W-1:0]   cfg_data
);
    import srgbl_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WHITE_W-1:0] white_x_reg, white_y_reg, white_z_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [SLOPE_W-1:0] slope_reg;
    logic [WHITE_W-1:0] wx, wy, wz;
    logic [D_W-1:0]     dx_reg, dy_reg, dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_x_reg <= WHITE_X_RST;
            white_y_reg <= WHITE_Y_RST;
            white_z_reg <= WHITE_Z_RST;
            thr_reg     <= THR_RST;
            slope_reg   <= SLOPE_RST;
        end
        else if (cfg_write)
        begin
            case (srgbl_reg_t'(cfg_index))
                REG_WHITE_X:      white_x_reg <= cfg_data[WHITE_W-1:0];
                REG_WHITE_Y:      white_y_reg <= cfg_data[WHITE_W-1:0];
                REG_WHITE_Z:      white_z_reg <= cfg_data[WHITE_W-1:0];
                REG_CUBE_THR:     thr_reg     <= cfg_data[THR_W-1:0];
                REG_LINEAR_SLOPE: slope_reg   <= cfg_data[SLOPE_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero white reads as one
    assign wx = (white_x_reg == '0) ? WHITE_W'(1) : white_x_reg;
    assign wy = (white_y_reg == '0) ? WHITE_W'(1) : white_y_reg;
    assign wz = (white_z_reg == '0) ? WHITE_W'(1) : white_z_reg;

    always_ff @(posedge clk)
    begin
        dx_reg <= D_W'(wx) * D_W'(100);
        dy_reg <= D_W'(wy) * D_W'(100);
        dz_reg <= D_W'(wz) * D_W'(100);
    end

    // front
    logic             take;
    logic             front_valid;
    srgbl_xyz_t       front_xyz;
    logic [1:0]       inflight;
    srgbl_xyz_t       fifo_rdata;
    logic             fifo_empty, fifo_full;
    logic [CNT_W-1:0] fifo_count;

    // the back pops every cycle the queue holds an entry
    assign take = start && !busy;
    assign busy = ((CNT_W + 2)'(fifo_count) - (CNT_W + 2)'(!fifo_empty)
                   + (CNT_W + 2)'(inflight)) >= (CNT_W + 2)'(FIFO_DEPTH);

    srgbl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .pixel     (pixel),
        .out_valid (front_valid),
        .xyz       (front_xyz),
        .inflight  (inflight)
    );

    srgbl_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_xyz),
        .pop   (!fifo_empty),
        .rdata (fifo_rdata),
        .empty (fifo_empty),
        .full  (fifo_full),
        .count (fifo_count)
    );

    // back: ratio numerators
    logic           n_valid_reg;
    logic [N_W-1:0] nx_reg, ny_reg, nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else
        begin
            n_valid_reg <= !fifo_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg <= (N_W'(fifo_rdata.sx) << 10) + N_W'(wx) * N_W'(50);
        ny_reg <= (N_W'(fifo_rdata.sy) << 10) + N_W'(wy) * N_W'(50);
        nz_reg <= (N_W'(fifo_rdata.sz) << 10) + N_W'(wz) * N_W'(50);
    end

    logic           tx_valid, ty_valid, tz_valid;
    logic [Q_W-1:0] tx, ty, tz;
    logic           px_valid, py_valid, pz_valid;
    logic [F_W-1:0] fx, fy, fz;

    srgbl_div u_div_x (.clk(clk), .rst_n(rst_n), .valid_in(n_valid_reg), .num(nx_reg),
                       .den(dx_reg), .valid_out(tx_valid), .quot(tx));
    srgbl_div u_div_y (.clk(clk), .rst_n(rst_n), .valid_in(n_valid_reg), .num(ny_reg),
                       .den(dy_reg), .valid_out(ty_valid), .quot(ty));
    srgbl_div u_div_z (.clk(clk), .rst_n(rst_n), .valid_in(n_valid_reg), .num(nz_reg),
                       .den(dz_reg), .valid_out(tz_valid), .quot(tz));

    srgbl_pivot u_piv_x (.clk(clk), .rst_n(rst_n), .valid_in(tx_valid), .t(tx),
                         .thr(thr_reg), .slope(slope_reg), .valid_out(px_valid), .f_out(fx));
    srgbl_pivot u_piv_y (.clk(clk), .rst_n(rst_n), .valid_in(ty_valid), .t(ty),
                         .thr(thr_reg), .slope(slope_reg), .valid_out(py_valid), .f_out(fy));
    srgbl_pivot u_piv_z (.clk(clk), .rst_n(rst_n), .valid_in(tz_valid), .t(tz),
                         .thr(thr_reg), .slope(slope_reg), .valid_out(pz_valid), .f_out(fz));

    // output scaling
    logic               o1_valid_reg;
    logic signed [34:0] v_reg;
    logic signed [36:0] da_reg, db_reg;
    logic signed [26:0] dxy, dyz;
    logic [33:0]        l_round;
    logic               done_reg;
    srgbl_lab_t         lab_reg;

    function automatic logic signed [15:0] round_sat(input logic signed [36:0] d);
        logic [36:0]        mag;
        logic [36:0]        q;
        logic signed [37:0] sq;
        mag = d[36] ? 37'(-d) : 37'(d);
        q   = (mag + 37'd2048) >> 12;
        sq  = d[36] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (sq > 38'sd32767)
        begin
            sq = 38'sd32767;
        end
        else if (sq < -38'sd32768)
        begin
            sq = -38'sd32768;
        end
        return sq[15:0];
    endfunction

    assign dxy     = $signed({1'b0, fx}) - $signed({1'b0, fy});
    assign dyz     = $signed({1'b0, fy}) - $signed({1'b0, fz});
    assign l_round = (v_reg[33:0] + 34'd2048) >> 12;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            o1_valid_reg <= px_valid;
            done_reg     <= o1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg  <= $signed(35'(fy) * 35'd116) - 35'sd16777216;
        da_reg <= 37'(dxy) * 37'sd500;
        db_reg <= 37'(dyz) * 37'sd200;
        if (v_reg > 35'sd0)
        begin
            lab_reg.lightness <= (l_round > 34'd32767) ? 15'h7fff : l_round[14:0];
        end
        else
        begin
            lab_reg.lightness <= '0;
        end
        lab_reg.green_red   <= round_sat(da_reg);
        lab_reg.blue_yellow <= round_sat(db_reg);
    end

    assign done = done_reg;
    assign lab  = lab_reg;

    // items accepted but not yet delivered
    logic [7:0] outstanding_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else if (take && !done_reg)
        begin
            outstanding_reg <= outstanding_reg + 8'd1;
        end
        else if (done_reg && !take)
        begin
            outstanding_reg <= outstanding_reg - 8'd1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid |-> !fifo_full)
        else $error("queue overflow");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (px_valid == py_valid) && (py_valid == pz_valid))
        else $error("channel lanes out of step");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (outstanding_reg != 8'd0))
        else $error("result without accepted pixel");

    a_done_follows_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        px_valid |=> ##1 done)
        else $error("pivot result lost");

endmodule
